>>> sv/modular_scalar_multiply_add_defines.svh
// Assertion macros for the modular multiply-add block.
// No dependencies; included by the top level.
`ifndef MODULAR_SCALAR_MULTIPLY_ADD_DEFINES_SVH
`define MODULAR_SCALAR_MULTIPLY_ADD_DEFINES_SVH

// check a property at every clock outside reset
`define MSMA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define MSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/msma_pkg.sv
// Shared types and register codes of the modular multiply-add block.
// No dependencies.
package msma_pkg;
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MODULUS = 2'd0;
	localparam cfg_idx_t CFG_SCALAR  = 2'd1;
	localparam int CFG_IDX_BITS = 2;
endpackage

>>> sv/msma_if.sv
// Request channels of the modular multiply-add block: operand pair and result.
// Depends on nothing.
interface msma_in_if #(parameter int W = 64);
	logic         valid;
	logic         ready;
	logic [W-1:0] addend;
	logic [W-1:0] multiplicand;
	modport source (output valid, addend, multiplicand, input ready);
	modport sink   (input valid, addend, multiplicand, output ready);
endinterface

interface msma_out_if #(parameter int W = 64);
	logic         valid;
	logic         ready;
	logic [W-1:0] sum_residue;
	modport source (output valid, sum_residue, input ready);
	modport sink   (input valid, sum_residue, output ready);
endinterface

>>> sv/modular_scalar_multiply_add.sv
// Throughput: one request per cycle; the whole pipeline holds while the result waits.
// Stages: split-product multiply, product-sum, then one restoring remainder step per bit.
// Reset: modulus 2, scalar 0, all stage valid bits cleared.
// Depends on msma_pkg, msma_if and the assertion macro header.
`include "modular_scalar_multiply_add_defines.svh"
module modular_scalar_multiply_add import msma_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]    cfg_data,
	msma_in_if.sink                 operands,
	msma_out_if.source              results
);
	localparam int W  = WORD_BITS;
	localparam int LB = W / 2;
	localparam int HB = W - LB;
	localparam int VB = 2 * W + 1;
	localparam int K  = VB;

	logic [W-1:0] modulus_q, scalar_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(2);
			scalar_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODULUS: modulus_q <= cfg_data;
				CFG_SCALAR:  scalar_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic step_vld_s3 [K];
	logic [W-1:0] step_rem_s3 [K];
	logic [VB-1:0] step_val_s3 [K];

	assign en = !step_vld_s3[K-1] || results.ready;
	assign operands.ready = en;

	// stage 1: partial products
	logic vld_s1;
	logic [W-1:0] add_s1;
	logic [2*LB-1:0] p00_s1;
	logic [W-1:0] p01_s1, p10_s1;
	logic [2*HB-1:0] p11_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= operands.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			add_s1 <= operands.addend;
			p00_s1 <= scalar_q[LB-1:0] * operands.multiplicand[LB-1:0];
			p01_s1 <= scalar_q[LB-1:0] * operands.multiplicand[W-1:LB];
			p10_s1 <= scalar_q[W-1:LB] * operands.multiplicand[LB-1:0];
			p11_s1 <= scalar_q[W-1:LB] * operands.multiplicand[W-1:LB];
		end
	end

	// stage 2: full product-sum
	logic vld_s2;
	logic [VB-1:0] val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2 <= VB'(p00_s1) + (VB'(p01_s1) << LB) + (VB'(p10_s1) << LB)
				+ (VB'(p11_s1) << (2 * LB)) + VB'(add_s1);
		end
	end

	// stage 3: one product-sum bit taken into the remainder per step, top bit first
	for (genvar k = 0; k < K; k++) begin : g_step
		logic          vld_in;
		logic [W-1:0]  rem_in;
		logic [VB-1:0] val_in;
		logic [W:0]    trial;
		logic [W:0]    diff;
		logic [W-1:0]  rem_nx;

		if (k == 0) begin : g_first
			assign vld_in = vld_s2;
			assign rem_in = '0;
			assign val_in = val_s2;
		end else begin : g_next
			assign vld_in = step_vld_s3[k-1];
			assign rem_in = step_rem_s3[k-1];
			assign val_in = step_val_s3[k-1];
		end

		always_comb begin
			trial = {rem_in, val_in[VB-1-k]};
			diff  = trial - {1'b0, modulus_q};
			if (trial >= {1'b0, modulus_q}) rem_nx = diff[W-1:0];
			else rem_nx = trial[W-1:0];
			if (k == K - 1 && modulus_q == '0) rem_nx = '0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) step_vld_s3[k] <= 1'b0;
			else if (en) step_vld_s3[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_rem_s3[k] <= rem_nx;
				step_val_s3[k] <= val_in;
			end
		end
	end

	assign results.valid       = step_vld_s3[K-1];
	assign results.sum_residue = step_rem_s3[K-1];

	`MSMA_ASSERT(a_res_below_mod, clk, arst_n,
		!results.valid || modulus_q == '0 || results.sum_residue < modulus_q,
		"result not below modulus")
	`MSMA_ASSERT(a_zero_mod, clk, arst_n,
		!results.valid || modulus_q != '0 || results.sum_residue == '0,
		"zero modulus gives nonzero result")
	`MSMA_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en,
		$stable(vld_s1) && $stable(vld_s2) && $stable(step_vld_s3[0]),
		"pipeline moved during stall")
	`MSMA_ASSERT_NEXT(a_accept_enters, clk, arst_n, operands.valid && operands.ready,
		vld_s1, "accepted request lost at entry")
endmodule
